@@ rtl/hal_pkg.sv @@
// ---------------------------------------------------------------------------
// hal_pkg: shared definitions for the humidity ADC linearizer
// Field widths, register codes, datapath widths, sequencer states and the
// fixed sensor linearization table.
// ---------------------------------------------------------------------------
package hal_pkg;

   localparam int ADC_W    = 12;
   localparam int TEMP_W   = 12;
   localparam int HUM_W    = 14;
   localparam int FLAG_W   = 2;
   localparam int CSR_W    = 16;
   localparam int APB_W    = 32;
   localparam int PADDR_W  = 3;

   // register index, taken from paddr[2]
   localparam logic REG_COMP_CONSTANT = 1'b0;
   localparam logic REG_COMP_SLOPE    = 1'b1;

   localparam logic [CSR_W-1:0] COMP_CONSTANT_RST = 16'd17279;
   localparam logic [CSR_W-1:0] COMP_SLOPE_RST    = 16'd2265;

   localparam logic [FLAG_W-1:0] FLAG_INSIDE = 2'd0;
   localparam logic [FLAG_W-1:0] FLAG_BELOW  = 2'd1;
   localparam logic [FLAG_W-1:0] FLAG_ABOVE  = 2'd2;

   localparam logic [HUM_W-1:0] HUM_MAX = 14'h3FFF;
   localparam int unsigned      STEP_HUNDREDTHS = 1000;

   // table
   localparam int ROM_POINTS = 11;
   localparam int ROM_IDX_W  = 4;

   // datapath widths, set by the table spacing (largest gap 300 codes)
   localparam int DX_W     = 9;   // hi - lo
   localparam int M_W      = 12;  // seg*dx + offset, below 3000
   localparam int NUM_W    = 22;  // 1000 * (seg*dx + offset)
   localparam int KT_W     = 29;  // K * T, signed
   localparam int D_W      = 30;  // (B << 10) - K*T, signed
   localparam int DMAG_W   = 28;  // positive divisor magnitude
   localparam int DEN_W    = DX_W + DMAG_W;
   localparam int FRAC_SH  = 24;
   localparam int REM_W    = NUM_W + FRAC_SH + 1;
   localparam int QUO_W    = HUM_W + 1;   // top bit flags overflow
   localparam int DIV_W    = DEN_W + HUM_W;
   localparam int CNT_W    = 4;

   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_RANGE  = 8'b0000_0010,
      S_SEARCH = 8'b0000_0100,
      S_PREP1  = 8'b0000_1000,
      S_PREP2  = 8'b0001_0000,
      S_PREP3  = 8'b0010_0000,
      S_DIV    = 8'b0100_0000,
      S_OUT    = 8'b1000_0000
   } state_type;

   function automatic logic [ADC_W-1:0] rom_point(input logic [ROM_IDX_W-1:0] idx);
      logic [ADC_W-1:0] pt;
      case (idx)
         4'd0:    pt = 12'd620;
         4'd1:    pt = 12'd918;
         4'd2:    pt = 12'd1134;
         4'd3:    pt = 12'd1411;
         4'd4:    pt = 12'd1669;
         4'd5:    pt = 12'd1904;
         4'd6:    pt = 12'd2204;
         4'd7:    pt = 12'd2482;
         4'd8:    pt = 12'd2782;
         4'd9:    pt = 12'd3060;
         4'd10:   pt = 12'd3227;
         default: pt = 12'd0;
      endcase
      return pt;
   endfunction

endpackage

@@ rtl/humidity_adc_linearizer.sv @@
// Outside the table the sequencer goes from the range check straight to output;
// inside it, the serial segment search (seg = segment index 0..9) and the 15-step
// divider run first, and a non-positive divisor skips the divider. A new sample is
// taken only once the sequencer is back in idle; result stalls hold it in output.
// Reset: synchronous, active high; idles the sequencer, clears output valid,
// loads comp_constant = 17279 and comp_slope = 2265.
// ---------------------------------------------------------------------------
// humidity_adc_linearizer
// Piecewise-linear table interpolation of a humidity ADC sample followed by
// temperature compensation, done as one exact rounded division.
// ---------------------------------------------------------------------------
module humidity_adc_linearizer
   import hal_pkg::*;
#(
   parameter int unsigned TABLE_POINTS = 11
) (
   input  logic                     clock,
   input  logic                     reset,
   // input channel
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [ADC_W-1:0]         req_adc_sample,
   input  logic signed [TEMP_W-1:0] req_temperature,
   // result channel
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [HUM_W-1:0]         rsp_humidity,
   output logic [FLAG_W-1:0]        rsp_range_flag,
   // configuration port
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [PADDR_W-1:0]       paddr,
   input  logic [APB_W-1:0]         pwdata,
   output logic [APB_W-1:0]         prdata,
   output logic                     pready
);

   localparam int unsigned PTS_MIN = (TABLE_POINTS < ROM_POINTS) ? TABLE_POINTS : ROM_POINTS;
   localparam int unsigned POINTS_USED = (PTS_MIN < 2) ? 2 : PTS_MIN;
   localparam int SEG_W = $clog2(POINTS_USED);
   localparam logic [SEG_W-1:0] LAST_SEG = SEG_W'(POINTS_USED - 2);
   localparam logic [ADC_W-1:0] FIRST_PT = rom_point(ROM_IDX_W'(0));
   localparam logic [ADC_W-1:0] LAST_PT  = rom_point(ROM_IDX_W'(POINTS_USED - 1));
   localparam int unsigned TOP_HUM = (POINTS_USED - 1) * STEP_HUNDREDTHS;
   localparam logic [HUM_W-1:0] ABOVE_HUM = (TOP_HUM > 16383) ? HUM_MAX : HUM_W'(TOP_HUM);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(QUO_W - 1);

   state_type state_ff, state_in;

   logic [CSR_W-1:0]         comp_constant_ff, comp_constant_in;
   logic [CSR_W-1:0]         comp_slope_ff, comp_slope_in;

   logic [ADC_W-1:0]         adc_ff, adc_in;
   logic signed [TEMP_W-1:0] temp_ff, temp_in;
   logic [SEG_W-1:0]         seg_ff, seg_in;
   logic signed [KT_W-1:0]   kt_ff, kt_in;
   logic signed [D_W-1:0]    d_ff, d_in;
   logic [DX_W-1:0]          dx_ff, dx_in;
   logic [M_W-1:0]           m_ff, m_in;
   logic [NUM_W-1:0]         num_ff, num_in;
   logic [DEN_W-1:0]         den_ff, den_in;
   logic [REM_W-1:0]         rem_ff, rem_in;
   logic [DIV_W-1:0]         divisor_ff, divisor_in;
   logic [QUO_W-1:0]         quo_ff, quo_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic [HUM_W-1:0]         res_hum_ff, res_hum_in;
   logic [FLAG_W-1:0]        res_flag_ff, res_flag_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [HUM_W-1:0]         rsp_hum_ff, rsp_hum_in;
   logic [FLAG_W-1:0]        rsp_flag_ff, rsp_flag_in;

   logic [ROM_IDX_W-1:0]     lo_idx;
   logic [ADC_W-1:0]         lo_pt, hi_pt;
   logic                     csr_wr;
   logic                     out_free;
   logic                     d_pos;
   logic [DIV_W:0]           sub;
   logic                     ge;
   logic [QUO_W-1:0]         quo_next;

   assign pready    = 1'b1;
   assign csr_wr    = psel & penable & pwrite;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_humidity   = rsp_hum_ff;
   assign rsp_range_flag = rsp_flag_ff;

   always_comb begin
      prdata = '0;
      case (paddr[2])
         REG_COMP_CONSTANT: prdata = APB_W'(comp_constant_ff);
         REG_COMP_SLOPE:    prdata = APB_W'(comp_slope_ff);
         default:           prdata = '0;
      endcase
   end

   always_comb begin
      comp_constant_in = comp_constant_ff;
      comp_slope_in    = comp_slope_ff;
      if (csr_wr) begin
         if (paddr[2] == REG_COMP_CONSTANT) comp_constant_in = pwdata[CSR_W-1:0];
         else comp_slope_in = pwdata[CSR_W-1:0];
      end
   end

   assign lo_idx   = ROM_IDX_W'(seg_ff);
   assign lo_pt    = rom_point(lo_idx);
   assign hi_pt    = rom_point(lo_idx + ROM_IDX_W'(1));
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign d_pos    = !d_ff[D_W-1] && (d_ff != '0);

   // subtract/compare unit of the divider
   assign sub      = {1'b0, DIV_W'(rem_ff)} - {1'b0, divisor_ff};
   assign ge       = !sub[DIV_W];
   assign quo_next = {quo_ff[QUO_W-2:0], ge};

   always_comb begin
      state_in    = state_ff;
      adc_in      = adc_ff;
      temp_in     = temp_ff;
      seg_in      = seg_ff;
      kt_in       = kt_ff;
      d_in        = d_ff;
      dx_in       = dx_ff;
      m_in        = m_ff;
      num_in      = num_ff;
      den_in      = den_ff;
      rem_in      = rem_ff;
      divisor_in  = divisor_ff;
      quo_in      = quo_ff;
      cnt_in      = cnt_ff;
      res_hum_in  = res_hum_ff;
      res_flag_in = res_flag_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_hum_in   = rsp_hum_ff;
      rsp_flag_in  = rsp_flag_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               adc_in   = req_adc_sample;
               temp_in  = req_temperature;
               state_in = S_RANGE;
            end
         end
         S_RANGE: begin
            kt_in  = KT_W'($signed({1'b0, comp_slope_ff}) * temp_ff);
            seg_in = '0;
            if (adc_ff <= FIRST_PT) begin
               res_hum_in  = '0;
               res_flag_in = FLAG_BELOW;
               state_in    = S_OUT;
            end else if (adc_ff >= LAST_PT) begin
               res_hum_in  = ABOVE_HUM;
               res_flag_in = FLAG_ABOVE;
               state_in    = S_OUT;
            end else begin
               state_in = S_SEARCH;
            end
         end
         S_SEARCH: begin
            // advance while the next point is still at or below the sample
            if (seg_ff != LAST_SEG && hi_pt <= adc_ff) seg_in = seg_ff + SEG_W'(1);
            else state_in = S_PREP1;
         end
         S_PREP1: begin
            d_in  = D_W'($signed({1'b0, comp_constant_ff, 10'b0})) - D_W'(kt_ff);
            dx_in = DX_W'(hi_pt - lo_pt);
            m_in  = M_W'(seg_ff) * M_W'(DX_W'(hi_pt - lo_pt)) + M_W'(adc_ff - lo_pt);
            state_in = S_PREP2;
         end
         S_PREP2: begin
            num_in = NUM_W'(m_ff) * NUM_W'(STEP_HUNDREDTHS);
            den_in = {{(DEN_W-DX_W){1'b0}}, dx_ff}
                   * {{(DEN_W-DMAG_W){1'b0}}, d_ff[DMAG_W-1:0]};
            if (!d_pos) begin
               res_hum_in  = HUM_MAX;
               res_flag_in = FLAG_INSIDE;
               state_in    = S_OUT;
            end else begin
               state_in = S_PREP3;
            end
         end
         S_PREP3: begin
            // add half the divisor for round half up
            rem_in     = REM_W'({num_ff, {FRAC_SH{1'b0}}}) + REM_W'(den_ff >> 1);
            divisor_in = {den_ff, {HUM_W{1'b0}}};
            quo_in     = '0;
            cnt_in     = '0;
            state_in   = S_DIV;
         end
         S_DIV: begin
            if (ge) rem_in = sub[REM_W-1:0];
            quo_in     = quo_next;
            divisor_in = divisor_ff >> 1;
            cnt_in     = cnt_ff + CNT_W'(1);
            if (cnt_ff == LAST_STEP) begin
               res_hum_in  = quo_next[QUO_W-1] ? HUM_MAX : quo_next[HUM_W-1:0];
               res_flag_in = FLAG_INSIDE;
               state_in    = S_OUT;
            end
         end
         S_OUT: begin
            // hold until the output register is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_hum_in   = res_hum_ff;
               rsp_flag_in  = res_flag_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         rsp_valid_ff     <= 1'b0;
         comp_constant_ff <= COMP_CONSTANT_RST;
         comp_slope_ff    <= COMP_SLOPE_RST;
      end else begin
         state_ff         <= state_in;
         rsp_valid_ff     <= rsp_valid_in;
         comp_constant_ff <= comp_constant_in;
         comp_slope_ff    <= comp_slope_in;
      end
   end

   always_ff @(posedge clock) begin
      adc_ff      <= adc_in;
      temp_ff     <= temp_in;
      seg_ff      <= seg_in;
      kt_ff       <= kt_in;
      d_ff        <= d_in;
      dx_ff       <= dx_in;
      m_ff        <= m_in;
      num_ff      <= num_in;
      den_ff      <= den_in;
      rem_ff      <= rem_in;
      divisor_ff  <= divisor_in;
      quo_ff      <= quo_in;
      cnt_ff      <= cnt_in;
      res_hum_ff  <= res_hum_in;
      res_flag_ff <= res_flag_in;
      rsp_hum_ff  <= rsp_hum_in;
      rsp_flag_ff <= rsp_flag_in;
   end

endmodule
